>>> rtl/core/rppd_pkg.sv
// ----------------------------------------------------------------------------
// rppd_pkg
// shared constants and types of the rc ppm/pwm pulse decoder
// ----------------------------------------------------------------------------
package rppd_pkg;

   localparam int CHANNELS = 6;
   localparam int PWM_PINS = 4;

   localparam int TIME_W  = 32;
   localparam int PIN_W   = 2;
   localparam int CH_W    = 3;
   localparam int PULSE_W = 8;
   localparam int THR_W   = 16;
   localparam int IV_W    = 12;
   localparam int QUOT_W  = 30;

   localparam logic [TIME_W-1:0] PPM_MIN_US    = 32'd500;
   localparam logic [TIME_W-1:0] PPM_MAX_US    = 32'd2500;
   localparam logic [THR_W-1:0]  BLANK_RESET   = 16'd3000;
   // ceil(2^34 / 5), exact floor(x / 5) for any 32-bit x after >> 34
   localparam logic [TIME_W-1:0] RECIP5_32     = 32'hCCCC_CCCD;
   // ceil(2^14 / 5), exact floor(x / 5) for x below 4096 after >> 14
   localparam logic [IV_W-1:0]   RECIP5_12     = 12'd3277;

   // request word: pin_index, level, time_us
   localparam int REQ_DATA_W    = 40;
   localparam int REQ_PIN_LSB   = 0;
   localparam int REQ_LEVEL_BIT = 2;
   localparam int REQ_TIME_LSB  = 3;

   // response word: channel, width_us, written, signal_seen
   localparam int RSP_DATA_W    = 40;
   localparam int RSP_CH_LSB    = 0;
   localparam int RSP_WIDTH_LSB = 3;
   localparam int RSP_WR_BIT    = 35;
   localparam int RSP_SIG_BIT   = 36;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic REG_DECODE_MODE = 1'b0;
   localparam logic REG_BLANK_THR   = 1'b1;

   localparam logic MODE_PPM = 1'b0;
   localparam logic MODE_PWM = 1'b1;

   typedef struct packed {
      logic [CH_W-1:0]   ch;
      logic              wr;
      logic              sig;
      logic              avg;
      logic [QUOT_W-1:0] quot;
      logic [2:0]        old_lo;
      logic [IV_W-1:0]   iv;
      logic [TIME_W-1:0] pwm_width;
   } stage_type;

endpackage

>>> rtl/core/rc_ppm_pwm_pulse_decoder_unit.sv
// ----------------------------------------------------------------------------
// rc_ppm_pwm_pulse_decoder_unit
// decodes rc receiver ppm frames or pwm pulse widths from timestamped edges
// ----------------------------------------------------------------------------
// req channel: one word per pin edge (pin, level, microsecond timestamp).
// rsp channel: exactly one word per edge (channel, stored width, written,
// signal seen), in edge order.
// csr port: apb-style, decode_mode at 0x0, blank_threshold_us at 0x4;
// write only while no edge is in flight.
// path: an accepted word passes the input, update and output registers in turn
// before it shows on rsp. throughput: one edge per cycle unless rsp_tready holds
// the output back; the ppm averaging multiply by 1/5 is split over the decode
// and update stages, each holding one multiplier.
// the input, update and output registers form a three-deep pipeline; when
// rsp_tready is low the pipeline fills and req_tready drops once all three
// stages hold a word, and nothing is lost.
// reset: synchronous, clears the pipeline, stored widths, rise times, frame
// state and registers (ppm mode, blank threshold 3000 us).
// ----------------------------------------------------------------------------
module rc_ppm_pwm_pulse_decoder_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [1:0] pin_index, [2] level, [34:3] time_us, [39:35] zero
   input  logic [rppd_pkg::REQ_DATA_W-1:0]   req_tdata,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [2:0] channel, [34:3] width_us, [35] written, [36] signal_seen, [39:37] zero
   output logic [rppd_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [rppd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [rppd_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [rppd_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   localparam int TW = rppd_pkg::TIME_W;

   // configuration
   logic                            mode_ff, mode_in;
   logic [rppd_pkg::THR_W-1:0]      thr_ff, thr_in;
   logic                            csr_wr;
   logic                            csr_idx;

   // decoder state
   logic [TW-1:0]                   last_edge_ff, last_edge_in;
   logic [rppd_pkg::PULSE_W-1:0]    pulse_ff, pulse_in;
   logic [TW-1:0]                   width_ff [rppd_pkg::CHANNELS];
   logic [TW-1:0]                   width_in [rppd_pkg::CHANNELS];
   logic [TW-1:0]                   rise_ff  [rppd_pkg::PWM_PINS];
   logic [TW-1:0]                   rise_in  [rppd_pkg::PWM_PINS];

   // pipeline
   logic                            a_valid_ff, a_valid_in;
   logic [rppd_pkg::PIN_W-1:0]      a_pin_ff, a_pin_in;
   logic                            a_level_ff, a_level_in;
   logic [TW-1:0]                   a_time_ff, a_time_in;
   logic                            b_valid_ff, b_valid_in;
   rppd_pkg::stage_type             b_ff, b_in;
   logic                            out_valid_ff, out_valid_in;
   logic [rppd_pkg::RSP_DATA_W-1:0] out_data_ff, out_data_in;

   logic                            out_free, b_free, a_free, a_move, b_move, req_take;

   // decode stage
   logic [TW-1:0]                   interval;
   logic                            ppm_edge, frame, in_ch, in_range, pwm_ok;
   logic [TW-1:0]                   old_sel, rise_sel;
   logic [2*TW-1:0]                 quot_prod;
   rppd_pkg::stage_type             dec;

   // update stage
   logic [2:0]                      rem5;
   logic [rppd_pkg::IV_W-1:0]       small_num;
   logic [2*rppd_pkg::IV_W-1:0]     small_prod;
   logic [TW-1:0]                   avg_val, new_val, rep_width;

   // ---------------- csr ----------------
   assign csr_pready = 1'b1;
   assign csr_idx    = csr_paddr[2];
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      mode_in = mode_ff;
      thr_in  = thr_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            rppd_pkg::REG_DECODE_MODE: mode_in = csr_pwdata[0];
            rppd_pkg::REG_BLANK_THR:   thr_in  = csr_pwdata[rppd_pkg::THR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         rppd_pkg::REG_DECODE_MODE: csr_prdata = {{(rppd_pkg::CSR_DATA_W-1){1'b0}}, mode_ff};
         rppd_pkg::REG_BLANK_THR:
            csr_prdata = {{(rppd_pkg::CSR_DATA_W-rppd_pkg::THR_W){1'b0}}, thr_ff};
         default: csr_prdata = '0;
      endcase
   end

   // ---------------- flow control ----------------
   assign out_free   = !out_valid_ff || rsp_tready;
   assign b_free     = !b_valid_ff || out_free;
   assign a_free     = !a_valid_ff || b_free;
   assign b_move     = b_valid_ff && out_free;
   assign a_move     = a_valid_ff && b_free;
   assign req_tready = a_free;
   assign req_take   = req_tvalid && req_tready;

   assign a_valid_in   = a_free ? req_tvalid : a_valid_ff;
   assign b_valid_in   = b_free ? a_valid_ff : b_valid_ff;
   assign out_valid_in = out_free ? b_valid_ff : out_valid_ff;

   assign a_pin_in   = req_take ? req_tdata[rppd_pkg::REQ_PIN_LSB +: rppd_pkg::PIN_W] : a_pin_ff;
   assign a_level_in = req_take ? req_tdata[rppd_pkg::REQ_LEVEL_BIT] : a_level_ff;
   assign a_time_in  = req_take ? req_tdata[rppd_pkg::REQ_TIME_LSB +: TW] : a_time_ff;

   // ---------------- decode stage ----------------
   assign interval = a_time_ff - last_edge_ff;
   assign ppm_edge = (a_pin_ff == '0) && a_level_ff;
   assign frame    = interval > {{(TW-rppd_pkg::THR_W){1'b0}}, thr_ff};
   assign in_ch    = pulse_ff < rppd_pkg::PULSE_W'(rppd_pkg::CHANNELS);
   assign in_range = (interval > rppd_pkg::PPM_MIN_US) && (interval < rppd_pkg::PPM_MAX_US);
   assign pwm_ok   = ({1'b0, a_pin_ff} < 3'(rppd_pkg::PWM_PINS))
                     && ({1'b0, a_pin_ff} < 3'(rppd_pkg::CHANNELS));

   always_comb begin
      old_sel = '0;
      for (int i = 0; i < rppd_pkg::CHANNELS; i++) begin
         if (pulse_ff == rppd_pkg::PULSE_W'(i)) old_sel = width_ff[i];
      end
      rise_sel = '0;
      for (int i = 0; i < rppd_pkg::PWM_PINS; i++) begin
         if (a_pin_ff == rppd_pkg::PIN_W'(i)) rise_sel = rise_ff[i];
      end
   end

   assign quot_prod = old_sel * rppd_pkg::RECIP5_32;

   always_comb begin
      dec           = '0;
      dec.quot      = quot_prod[34 +: rppd_pkg::QUOT_W];
      dec.old_lo    = old_sel[2:0];
      dec.iv        = interval[rppd_pkg::IV_W-1:0];
      dec.pwm_width = a_time_ff - rise_sel;
      last_edge_in  = last_edge_ff;
      pulse_in      = pulse_ff;
      for (int i = 0; i < rppd_pkg::PWM_PINS; i++) rise_in[i] = rise_ff[i];
      if (mode_ff == rppd_pkg::MODE_PPM) begin
         if (ppm_edge) begin
            last_edge_in = a_time_ff;
            if (frame) begin
               pulse_in = '0;
               dec.sig  = 1'b1;
            end else begin
               pulse_in = pulse_ff + 1'b1;
               if (in_ch) begin
                  dec.ch  = pulse_ff[rppd_pkg::CH_W-1:0];
                  dec.wr  = in_range;
                  dec.avg = in_range;
               end
            end
         end
      end else if (pwm_ok) begin
         dec.ch = {1'b0, a_pin_ff};
         if (a_level_ff) begin
            for (int i = 0; i < rppd_pkg::PWM_PINS; i++) begin
               if (a_pin_ff == rppd_pkg::PIN_W'(i)) rise_in[i] = a_time_ff;
            end
         end else begin
            dec.wr  = 1'b1;
            dec.sig = 1'b1;
         end
      end
   end

   assign b_in = a_move ? dec : b_ff;

   // ---------------- update stage ----------------
   // (4*old + iv) / 5 = 4*(old/5) + (4*(old%5) + iv) / 5
   assign rem5       = b_ff.old_lo - 3'(b_ff.quot[2:0] * 3'd5);
   assign small_num  = {rem5, 2'b00} + b_ff.iv;
   assign small_prod = small_num * rppd_pkg::RECIP5_12;
   assign avg_val    = {b_ff.quot, 2'b00} + TW'(small_prod[2*rppd_pkg::IV_W-1:14]);
   assign new_val    = b_ff.avg ? avg_val : b_ff.pwm_width;

   always_comb begin
      rep_width = '0;
      for (int i = 0; i < rppd_pkg::CHANNELS; i++) begin
         if (b_ff.ch == rppd_pkg::CH_W'(i)) rep_width = width_ff[i];
         width_in[i] = width_ff[i];
         if (b_move && b_ff.wr && (b_ff.ch == rppd_pkg::CH_W'(i))) width_in[i] = new_val;
      end
      if (b_ff.wr) rep_width = new_val;
   end

   always_comb begin
      out_data_in = out_data_ff;
      if (b_move) begin
         out_data_in = '0;
         out_data_in[rppd_pkg::RSP_CH_LSB +: rppd_pkg::CH_W] = b_ff.ch;
         out_data_in[rppd_pkg::RSP_WIDTH_LSB +: TW]          = rep_width;
         out_data_in[rppd_pkg::RSP_WR_BIT]                   = b_ff.wr;
         out_data_in[rppd_pkg::RSP_SIG_BIT]                  = b_ff.sig;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= rppd_pkg::MODE_PPM;
         thr_ff       <= rppd_pkg::BLANK_RESET;
         last_edge_ff <= '0;
         pulse_ff     <= '0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
         out_valid_ff <= 1'b0;
         for (int i = 0; i < rppd_pkg::CHANNELS; i++) width_ff[i] <= '0;
         for (int i = 0; i < rppd_pkg::PWM_PINS; i++) rise_ff[i] <= '0;
      end else begin
         mode_ff      <= mode_in;
         thr_ff       <= thr_in;
         a_valid_ff   <= a_valid_in;
         b_valid_ff   <= b_valid_in;
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < rppd_pkg::CHANNELS; i++) width_ff[i] <= width_in[i];
         if (a_move) begin
            last_edge_ff <= last_edge_in;
            pulse_ff     <= pulse_in;
            for (int i = 0; i < rppd_pkg::PWM_PINS; i++) rise_ff[i] <= rise_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      a_pin_ff    <= a_pin_in;
      a_level_ff  <= a_level_in;
      a_time_ff   <= a_time_in;
      b_ff        <= b_in;
      out_data_ff <= out_data_in;
   end

endmodule

>>> rtl/core/rppd_checker.sv
// ----------------------------------------------------------------------------
// rppd_checker
// port-level checks of the rc ppm/pwm pulse decoder
// ----------------------------------------------------------------------------
module rppd_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [rppd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input logic                            csr_pready
);

   logic [rppd_pkg::CH_W-1:0] ch;
   logic                      wr;
   logic                      sig;

   assign ch  = rsp_tdata[rppd_pkg::RSP_CH_LSB +: rppd_pkg::CH_W];
   assign wr  = rsp_tdata[rppd_pkg::RSP_WR_BIT];
   assign sig = rsp_tdata[rppd_pkg::RSP_SIG_BIT];

   // pipeline empty after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high right after reset");

   // stalled word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response word changed");

   // reported channel within the store
   a_ch_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ch < rppd_pkg::CH_W'(rppd_pkg::CHANNELS))
      else $error("response channel out of range");

   // a frame start reports channel 0 without a write
   a_frame_ch0: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && sig && !wr |-> ch == '0)
      else $error("frame start reported on a nonzero channel");

   // with a free output an offered word is never blocked
   a_no_block: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && !rsp_tvalid && csr_pready |-> req_tready)
      else $error("request blocked while output is empty");

endmodule

bind rc_ppm_pwm_pulse_decoder_unit rppd_checker u_rppd_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .csr_pready (csr_pready)
);

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the rc ppm/pwm pulse decoder unit
// ----------------------------------------------------------------------------
// drives timestamped pin edges on req, checks every rsp word field by field
// against an in-bench decoder model. a directed table covers frame starts,
// interval limits, ignored edges, pulses past the last channel, timestamp wrap
// and pwm widths across the wrap; random phases then run well-formed ppm
// frames and pwm pulse trains with noise, under several register settings and
// idle/stall patterns, including one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb;

   localparam int LATENCY = 3;
   localparam int LIMIT   = 400000;
   localparam int HOLD_CYCLES = 300;
   localparam logic [rppd_pkg::CSR_ADDR_W-1:0] ADDR_MODE  = {rppd_pkg::REG_DECODE_MODE, 2'b00};
   localparam logic [rppd_pkg::CSR_ADDR_W-1:0] ADDR_BLANK = {rppd_pkg::REG_BLANK_THR, 2'b00};

   typedef struct packed {
      logic [rppd_pkg::CH_W-1:0]   ch;
      logic [rppd_pkg::TIME_W-1:0] width;
      logic                        written;
      logic                        seen;
   } decode_rsp_type;

   typedef struct packed {
      logic           typed;
      decode_rsp_type want;
   } pinned_type;

   typedef struct packed {
      logic                        mode;
      logic [rppd_pkg::THR_W-1:0]  thr;
      logic [rppd_pkg::PIN_W-1:0]  pin;
      logic                        lvl;
      logic [rppd_pkg::TIME_W-1:0] t;
      logic                        typed;
      decode_rsp_type              want;
   } dir_row_type;

   logic                              clock = 1'b0;
   logic                              reset = 1'b1;
   logic                              req_tvalid = 1'b0;
   logic                              req_tready;
   logic [rppd_pkg::REQ_DATA_W-1:0]   req_tdata = '0;
   logic                              rsp_tvalid;
   logic                              rsp_tready = 1'b1;
   logic [rppd_pkg::RSP_DATA_W-1:0]   rsp_tdata;
   logic                              csr_psel = 1'b0;
   logic                              csr_penable = 1'b0;
   logic                              csr_pwrite = 1'b0;
   logic [rppd_pkg::CSR_ADDR_W-1:0]   csr_paddr = '0;
   logic [rppd_pkg::CSR_DATA_W-1:0]   csr_pwdata = '0;
   logic [rppd_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   // decoder model state
   logic                              mode_m = rppd_pkg::MODE_PPM;
   logic [rppd_pkg::THR_W-1:0]        blank_m = rppd_pkg::BLANK_RESET;
   logic [rppd_pkg::TIME_W-1:0]       last_m = '0;
   logic [rppd_pkg::PULSE_W-1:0]      pulse_m = '0;
   logic [rppd_pkg::TIME_W-1:0]       width_m [rppd_pkg::CHANNELS];
   logic [rppd_pkg::TIME_W-1:0]       rise_m [rppd_pkg::PWM_PINS];

   decode_rsp_type                    report_q [$];
   pinned_type                        pinned_q [$];
   dir_row_type                       rows [$];

   int                                err_cnt = 0;
   int                                cycle_cnt = 0;
   int                                sent_cnt = 0;
   int                                idle_pct = 0;
   int                                stall_pct = 0;
   logic                              rsp_hold = 1'b0;
   logic [rppd_pkg::TIME_W-1:0]       now_us = '0;
   logic [rppd_pkg::PWM_PINS-1:0]     pin_up = '0;

   rc_ppm_pwm_pulse_decoder_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < rppd_pkg::CHANNELS; i++) width_m[i] = '0;
      for (int i = 0; i < rppd_pkg::PWM_PINS; i++) rise_m[i] = '0;
   end

   function automatic decode_rsp_type stored_report(input logic [rppd_pkg::CH_W-1:0] ch,
                                                    input logic wr, input logic sig);
      decode_rsp_type r;
      r.ch      = ch;
      r.width   = (ch < rppd_pkg::CHANNELS) ? width_m[ch] : '0;
      r.written = wr;
      r.seen    = sig;
      return r;
   endfunction

   function automatic decode_rsp_type decode_edge(input logic [rppd_pkg::PIN_W-1:0] pin,
                                                  input logic lvl,
                                                  input logic [rppd_pkg::TIME_W-1:0] t);
      logic [rppd_pkg::TIME_W-1:0]  iv;
      logic [rppd_pkg::PULSE_W-1:0] idx;
      logic [63:0]                  acc;
      logic [63:0]                  quo;
      logic                         wr;
      if (mode_m == rppd_pkg::MODE_PPM) begin
         if (pin != 0 || !lvl) return stored_report('0, 1'b0, 1'b0);
         iv = t - last_m;
         last_m = t;
         if (iv > {16'b0, blank_m}) begin
            pulse_m = '0;
            return stored_report('0, 1'b0, 1'b1);
         end
         idx = pulse_m;
         pulse_m = pulse_m + 1'b1;
         if (idx >= rppd_pkg::CHANNELS) return stored_report('0, 1'b0, 1'b0);
         wr = (iv > rppd_pkg::PPM_MIN_US) && (iv < rppd_pkg::PPM_MAX_US);
         if (wr) begin
            acc = {32'b0, width_m[idx]} * 64'd4 + {32'b0, iv};
            quo = acc / 64'd5;
            width_m[idx] = quo[rppd_pkg::TIME_W-1:0];
         end
         return stored_report(idx[rppd_pkg::CH_W-1:0], wr, 1'b0);
      end
      if (pin >= rppd_pkg::PWM_PINS || pin >= rppd_pkg::CHANNELS)
         return stored_report('0, 1'b0, 1'b0);
      if (lvl) begin
         rise_m[pin] = t;
         return stored_report(rppd_pkg::CH_W'(pin), 1'b0, 1'b0);
      end
      width_m[pin] = t - rise_m[pin];
      return stored_report(rppd_pkg::CH_W'(pin), 1'b1, 1'b1);
   endfunction

   // model runs on every accepted edge
   always @(posedge clock) begin : accept_blk
      decode_rsp_type p;
      pinned_type     tag;
      if (!reset && req_tvalid && req_tready) begin
         p = decode_edge(req_tdata[rppd_pkg::REQ_PIN_LSB +: rppd_pkg::PIN_W],
                         req_tdata[rppd_pkg::REQ_LEVEL_BIT],
                         req_tdata[rppd_pkg::REQ_TIME_LSB +: rppd_pkg::TIME_W]);
         tag = pinned_q.pop_front();
         report_q.push_back(tag.typed ? tag.want : p);
      end
   end

   always @(posedge clock) begin : check_blk
      decode_rsp_type want;
      decode_rsp_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ch      = rsp_tdata[rppd_pkg::RSP_CH_LSB +: rppd_pkg::CH_W];
         got.width   = rsp_tdata[rppd_pkg::RSP_WIDTH_LSB +: rppd_pkg::TIME_W];
         got.written = rsp_tdata[rppd_pkg::RSP_WR_BIT];
         got.seen    = rsp_tdata[rppd_pkg::RSP_SIG_BIT];
         if (report_q.size() == 0) begin
            err_cnt = err_cnt + 1;
            if (err_cnt <= 10)
               $display("unexpected word: ch %0d width %0d wr %0d sig %0d",
                        got.ch, got.width, got.written, got.seen);
         end else begin
            want = report_q.pop_front();
            if (got.ch !== want.ch || got.width !== want.width ||
                got.written !== want.written || got.seen !== want.seen) begin
               err_cnt = err_cnt + 1;
               if (err_cnt <= 10)
                  $display({"mismatch: expected ch %0d width %0d wr %0d sig %0d, ",
                            "got ch %0d width %0d wr %0d sig %0d"},
                           want.ch, want.width, want.written, want.seen,
                           got.ch, got.width, got.written, got.seen);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (rsp_hold) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt >= LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   task automatic send_edge(input logic [rppd_pkg::PIN_W-1:0] pin, input logic lvl,
                            input logic [rppd_pkg::TIME_W-1:0] t, input logic typed,
                            input decode_rsp_type want);
      pinned_type tag;
      tag.typed = typed;
      tag.want  = want;
      pinned_q.push_back(tag);
      while (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(rppd_pkg::REQ_DATA_W - rppd_pkg::TIME_W - rppd_pkg::PIN_W - 1){1'b0}},
                     t, lvl, pin};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sent_cnt++;
   endtask

   task automatic send_plain(input logic [rppd_pkg::PIN_W-1:0] pin, input logic lvl,
                             input logic [rppd_pkg::TIME_W-1:0] t);
      send_edge(pin, lvl, t, 1'b0, '0);
   endtask

   // wait until every word is back and the pipe is empty
   task automatic settle();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (report_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 3) @(posedge clock);
   endtask

   task automatic csr_put(input logic [rppd_pkg::CSR_ADDR_W-1:0] addr,
                          input logic [rppd_pkg::CSR_DATA_W-1:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
   endtask

   task automatic apply_config(input logic mode, input logic [rppd_pkg::THR_W-1:0] thr);
      csr_put(ADDR_MODE, {{(rppd_pkg::CSR_DATA_W-1){1'b0}}, mode});
      mode_m = mode;
      csr_put(ADDR_BLANK, {{(rppd_pkg::CSR_DATA_W-rppd_pkg::THR_W){1'b0}}, thr});
      blank_m = thr;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   task automatic ppm_frame(input int npulses);
      logic [rppd_pkg::TIME_W-1:0] iv;
      now_us = now_us + {16'b0, blank_m} + 32'd1 + $urandom_range(6000);
      send_plain('0, 1'b1, now_us);
      for (int i = 0; i < npulses; i++) begin
         case ($urandom_range(9))
            0: begin
               case ($urandom_range(5))
                  0: iv = rppd_pkg::PPM_MIN_US;
                  1: iv = rppd_pkg::PPM_MAX_US;
                  2: iv = rppd_pkg::PPM_MIN_US - 1;
                  3: iv = rppd_pkg::PPM_MAX_US + 1;
                  4: iv = '0;
                  default: iv = 32'd1;
               endcase
            end
            1: iv = $urandom_range(blank_m);
            default: iv = $urandom_range(rppd_pkg::PPM_MAX_US - 1, rppd_pkg::PPM_MIN_US + 1);
         endcase
         if ($urandom_range(99) < 15) send_plain('0, 1'b0, now_us + iv / 2);
         if ($urandom_range(99) < 5)
            send_plain(rppd_pkg::PIN_W'($urandom_range(3, 1)), 1'($urandom_range(1)),
                       now_us + iv / 3);
         if ($urandom_range(99) < 3)
            send_plain(rppd_pkg::PIN_W'($urandom_range(3)), 1'($urandom_range(1)), $urandom);
         now_us = now_us + iv;
         send_plain('0, 1'b1, now_us);
      end
   endtask

   task automatic pwm_edge();
      logic [rppd_pkg::PIN_W-1:0] pin;
      logic                       lvl;
      pin = rppd_pkg::PIN_W'($urandom_range(3));
      lvl = ($urandom_range(99) < 10) ? logic'($urandom_range(1)) : !pin_up[pin];
      now_us = now_us + (($urandom_range(99) < 5) ? $urandom : $urandom_range(2100, 1));
      pin_up[pin] = lvl;
      send_plain(pin, lvl, now_us);
   endtask

   task automatic feed(input logic mode, input int n, input logic long_frame);
      int start;
      logic first;
      start = sent_cnt;
      first = 1'b1;
      now_us = $urandom;
      while (sent_cnt - start < n) begin
         if (mode == rppd_pkg::MODE_PPM) begin
            // long frame walks the pulse counter through its wrap
            ppm_frame((long_frame && first) ? 260 : $urandom_range(9, 4));
         end else begin
            pwm_edge();
         end
         first = 1'b0;
      end
   endtask

   task automatic hold_rsp();
      rsp_hold <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic run_phase(input logic mode, input logic [rppd_pkg::THR_W-1:0] thr,
                            input int idle, input int stall, input int n,
                            input logic hold, input logic long_frame);
      settle();
      apply_config(mode, thr);
      idle_pct  <= idle;
      stall_pct <= stall;
      @(posedge clock);
      if (hold) begin
         fork
            feed(mode, n, long_frame);
            hold_rsp();
         join
      end else begin
         feed(mode, n, long_frame);
      end
   endtask

   function automatic dir_row_type mk_row(input logic mode,
                                          input logic [rppd_pkg::THR_W-1:0] thr,
                                          input logic [rppd_pkg::PIN_W-1:0] pin,
                                          input logic lvl,
                                          input logic [rppd_pkg::TIME_W-1:0] t,
                                          input logic typed,
                                          input logic [rppd_pkg::CH_W-1:0] ch,
                                          input logic [rppd_pkg::TIME_W-1:0] width,
                                          input logic wr, input logic sig);
      dir_row_type r;
      r.mode = mode;
      r.thr  = thr;
      r.pin  = pin;
      r.lvl  = lvl;
      r.t    = t;
      r.typed = typed;
      r.want.ch = ch;
      r.want.width = width;
      r.want.written = wr;
      r.want.seen = sig;
      return r;
   endfunction

   initial begin
      logic                       cur_mode;
      logic [rppd_pkg::THR_W-1:0] cur_thr;
      dir_row_type                row;

      // mode, threshold, pin, level, time, typed, ch, width, written, seen
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd10000,  1, 0, 0,   0, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd11500,  1, 0, 300, 1, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd13000,  1, 1, 300, 1, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd13500,  1, 2, 0,   0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd16000,  1, 3, 0,   0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd16501,  1, 4, 100, 1, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd18500,  1, 5, 399, 1, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd20000,  1, 0, 300, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 0, 32'd20500,  1, 0, 300, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 3, 1, 32'd21000,  1, 0, 300, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd23000,  1, 0, 300, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'd26001,  1, 0, 300, 0, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'hFFFF_FF00, 1, 0, 300, 0, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 3000, 0, 1, 32'h0000_0500, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 0,    0, 1, 32'h0000_0501, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 0,    0, 1, 32'h0000_0501, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 0, 1, 32'd1,   0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 0, 0, 32'd0,   1, 0,
                            32'hFFFF_FFFF, 1, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 3, 0, 32'h10,  1, 3, 32'h10, 1, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 3, 1, 32'hFFFF_FFF0, 1, 3,
                            32'h10, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 3, 0, 32'h10,  1, 3, 32'h20, 1, 1));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 2, 1, 32'h5555_5555, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PWM, 16'hFFFF, 2, 0, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 16'hFFFF, 0, 1, 32'h0010_0000, 0, 0, 0, 0, 0));
      rows.push_back(mk_row(rppd_pkg::MODE_PPM, 16'hFFFF, 0, 1, 32'h0010_03E8, 0, 0, 0, 0, 0));

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      cur_mode = rppd_pkg::MODE_PPM;
      cur_thr  = rppd_pkg::BLANK_RESET;
      foreach (rows[i]) begin
         row = rows[i];
         if (row.mode != cur_mode || row.thr != cur_thr) begin
            settle();
            apply_config(row.mode, row.thr);
            cur_mode = row.mode;
            cur_thr  = row.thr;
            @(posedge clock);
         end
         send_edge(row.pin, row.lvl, row.t, row.typed, row.want);
      end

      run_phase(rppd_pkg::MODE_PPM, 3000,  0,  0,  100, 1'b0, 1'b0);
      run_phase(rppd_pkg::MODE_PWM, 3000,  61, 0,  100, 1'b0, 1'b0);
      run_phase(rppd_pkg::MODE_PPM, 2200,  0,  61, 100, 1'b1, 1'b0);
      run_phase(rppd_pkg::MODE_PWM, 16'hFFFF, 22, 22, 100, 1'b0, 1'b0);
      run_phase(rppd_pkg::MODE_PPM, 16'hFFFF, 22, 22, 260, 1'b0, 1'b1);
      run_phase(rppd_pkg::MODE_PPM, 0,     0,  0,  30,  1'b0, 1'b0);
      run_phase(rppd_pkg::MODE_PPM, rppd_pkg::THR_W'($urandom_range(20000, 2600)),
                61, 61, 90, 1'b0, 1'b0);
      settle();

      if (err_cnt == 0 && report_q.size() == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
